/* rtl/core/urxf_pkg.sv */
// Shared types and constants for the UART receiver with ring FIFO.
// Used by the core and the testbench.
package urxf_pkg;

    // Serial frame format
    localparam int DATA_BITS = 8;
    localparam logic [7:0] DATA_MSB_MASK = 8'h80;

    // Timing register widths and reset values
    localparam int BIT_TICKS_W    = 16;
    localparam int FIRST_TICKS_W  = 17;
    localparam int ELAPSED_W      = 20;
    localparam int CFG_DATA_W     = 17;
    localparam int CFG_INDEX_W    = 4;
    localparam logic [BIT_TICKS_W-1:0]   BIT_TICKS_RESET   = 16'd8333;
    localparam logic [FIRST_TICKS_W-1:0] FIRST_TICKS_RESET = 17'd10610;

    // FIFO geometry
    localparam int FIFO_DEPTH_DEFAULT = 64;
    localparam int FILL_COUNT_W       = 6;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BIT_TICKS          = 4'd0,
        REG_FIRST_SAMPLE_TICKS = 4'd1
    } cfg_reg_t;

    // One tick of the receive line with FIFO requests
    typedef struct packed {
        logic rx_level;
        logic pop_req;
        logic clear;
    } sample_t;

    // FIFO status reported for one tick
    typedef struct packed {
        logic [7:0]              head_byte;
        logic                    head_valid;
        logic [FILL_COUNT_W-1:0] fill_count;
        logic                    receiving;
    } result_t;

endpackage

/* rtl/core/urxf_stream_if.sv */
// Valid/ready stream channel carrying one payload of type data_t.
// Depends on nothing; payload types come from urxf_pkg at instantiation.
interface urxf_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

/* rtl/core/uart_rx_with_ring_fifo_core.sv */
// UART 8N1 receiver feeding a ring FIFO, one input request per clock tick unless results stall.
// Depends on urxf_pkg and urxf_stream_if.
//
// Usage:
//   sample carries one tick of the oversampled receive line (rx_level) plus
//   pop_req and clear requests for the FIFO. result carries, for each accepted
//   sample, the FIFO head byte, head_valid, fill_count and the receiving flag
//   as they stood before that tick. cfg_wr_en/cfg_index/cfg_data write the
//   bit_ticks and first_sample_ticks timing registers; write them while idle.
//   Throughput: one sample request per cycle while result.ready is high. The result
//   of a sample is valid on the cycle after it is accepted, from a single
//   output register. The head byte comes from a registered FIFO memory read
//   at the next head index, with a bypass for a write to the head entry.
//   A stalled result channel holds its request; sample.ready drops only while
//   a result waits and result.ready is low, so no tick is lost.
//   The FIFO holds FIFO_DEPTH-1 bytes; a byte received while full is dropped.
//   Reset empties the FIFO, ends any frame and restores the timing registers;
//   memory contents are not cleared, since only written entries are read.
module uart_rx_with_ring_fifo_core #(
    parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    urxf_stream_if.sink                      sample,
    urxf_stream_if.source                    result,
    input  logic                             cfg_wr_en,
    input  logic [urxf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [urxf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import urxf_pkg::*;

    localparam int AW     = $clog2(FIFO_DEPTH);
    localparam int FILL_W = (AW + 1 > FILL_COUNT_W) ? AW + 1 : FILL_COUNT_W;
    localparam logic [AW:0]   DEPTH_VAL = (AW + 1)'(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST_IDX  = AW'(FIFO_DEPTH - 1);

    // Ring index advance with wrap at the depth
    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

    // Timing registers
    logic [BIT_TICKS_W-1:0]   bit_ticks_reg;
    logic [FIRST_TICKS_W-1:0] first_ticks_reg;

    // Receiver state
    logic                 busy_reg, busy_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [3:0]           bitnum_reg, bitnum_next;
    logic [7:0]           shift_reg, shift_next;
    logic                 last_level_reg, last_level_next;

    // FIFO state
    logic [7:0]    mem [FIFO_DEPTH];
    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [7:0]    rdata_reg;
    logic          byp_reg, byp_next;
    logic [7:0]    byp_data_reg;

    // Output register
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;

    logic                 accept;
    logic                 have;
    logic [AW:0]          fill;
    logic [FILL_W-1:0]    fill_ext;
    logic [7:0]           head_data;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [ELAPSED_W-1:0] target;
    logic                 push;
    logic                 mem_we;
    logic [AW-1:0]        wr_base;
    logic [AW-1:0]        wr_adv;
    result_t              res_now;

    assign sample.ready = !out_valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Fill level and head before this tick
    assign have      = wr_idx_reg != rd_idx_reg;
    assign fill      = (wr_idx_reg >= rd_idx_reg)
                     ? {1'b0, wr_idx_reg} - {1'b0, rd_idx_reg}
                     : {1'b0, wr_idx_reg} + DEPTH_VAL - {1'b0, rd_idx_reg};
    assign fill_ext  = FILL_W'(fill);
    assign head_data = byp_reg ? byp_data_reg : rdata_reg;

    always_comb
    begin
        res_now.head_byte  = have ? head_data : 8'd0;
        res_now.head_valid = have;
        res_now.fill_count = fill_ext[FILL_COUNT_W-1:0];
        res_now.receiving  = busy_reg;
    end

    // Bit timing compare
    assign elapsed_inc = elapsed_reg + ELAPSED_W'(1);
    assign target      = (bitnum_reg == 4'd0) ? ELAPSED_W'(first_ticks_reg)
                                              : ELAPSED_W'(bit_ticks_reg);

    // Advance the receiver on each accepted tick
    always_comb
    begin
        busy_next       = busy_reg;
        elapsed_next    = elapsed_reg;
        bitnum_next     = bitnum_reg;
        shift_next      = shift_reg;
        last_level_next = last_level_reg;
        push            = 1'b0;
        if (accept)
        begin
            last_level_next = sample.data.rx_level;
            if (busy_reg)
            begin
                elapsed_next = elapsed_inc;
                if (elapsed_inc >= target)
                begin
                    elapsed_next = '0;
                    if (bitnum_reg < 4'(DATA_BITS))
                    begin
                        shift_next  = (shift_reg >> 1)
                                    | (sample.data.rx_level ? DATA_MSB_MASK : 8'd0);
                        bitnum_next = bitnum_reg + 4'd1;
                    end
                    else
                    begin
                        push        = 1'b1;
                        busy_next   = 1'b0;
                        bitnum_next = 4'd0;
                    end
                end
            end
            else if (last_level_reg && !sample.data.rx_level)
            begin
                busy_next    = 1'b1;
                elapsed_next = '0;
                bitnum_next  = 4'd0;
                shift_next   = 8'd0;
            end
        end
    end

    // Apply clear or pop first, then push against the updated read index
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        wr_base     = wr_idx_reg;
        if (accept && sample.data.clear)
        begin
            rd_idx_next = '0;
            wr_base     = '0;
        end
        else if (accept && sample.data.pop_req && have)
        begin
            rd_idx_next = ring_next(rd_idx_reg);
        end
        wr_adv      = ring_next(wr_base);
        mem_we      = push && (wr_adv != rd_idx_next);
        wr_idx_next = mem_we ? wr_adv : wr_base;
        byp_next    = mem_we && (wr_base == rd_idx_next);
    end

    // Hold the result until taken, load on each accepted tick
    assign out_valid_next = accept || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_ticks_reg   <= BIT_TICKS_RESET;
            first_ticks_reg <= FIRST_TICKS_RESET;
            busy_reg        <= 1'b0;
            elapsed_reg     <= '0;
            bitnum_reg      <= 4'd0;
            shift_reg       <= 8'd0;
            last_level_reg  <= 1'b1;
            wr_idx_reg      <= '0;
            rd_idx_reg      <= '0;
            byp_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            elapsed_reg    <= elapsed_next;
            bitnum_reg     <= bitnum_next;
            shift_reg      <= shift_next;
            last_level_reg <= last_level_next;
            wr_idx_reg     <= wr_idx_next;
            rd_idx_reg     <= rd_idx_next;
            byp_reg        <= byp_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_BIT_TICKS:
                        bit_ticks_reg <= cfg_data[BIT_TICKS_W-1:0];
                    REG_FIRST_SAMPLE_TICKS:
                        first_ticks_reg <= cfg_data[FIRST_TICKS_W-1:0];
                    default:
                        ;
                endcase
            end
        end
    end

    // FIFO memory: write the received byte, read ahead at the next head index
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_base] <= shift_reg;
        end
        rdata_reg    <= mem[rd_idx_next];
        byp_data_reg <= shift_reg;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= res_now;
        end
    end

endmodule

/* rtl/core/urxf_checker.sv */
// Port-level checks for the UART receiver with ring FIFO, bound to the core.
// Depends on the core's ports only.
module urxf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] head_byte,
    input logic       head_valid,
    input logic [5:0] fill_count
);
    // Hold a stalled result request
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Stop taking ticks while a result waits
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("sample accepted while result stalled");

    // Every accepted tick yields a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after accepted sample");

    // An empty FIFO reports zero head byte and zero fill
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !head_valid |-> head_byte == 8'd0 && fill_count == 6'd0)
        else $error("empty FIFO reports data");
endmodule

bind uart_rx_with_ring_fifo_core urxf_checker u_urxf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .head_byte  (result.data.head_byte),
    .head_valid (result.data.head_valid),
    .fill_count (result.data.fill_count)
);

/* test/tb_top.sv */
// Testbench for uart_rx_with_ring_fifo_core: drives receive-line ticks with pop/clear
// requests and checks each reported FIFO status against a cycle-true tracker.
// Depends on urxf_pkg, urxf_stream_if and the core.
module tb_top;
    import urxf_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 4'd15;

    // Tracks receiver and FIFO state and holds the status expected for each tick
    class rx_fifo_tracker;
        logic [7:0]               store [FIFO_DEPTH_DEFAULT];
        logic [FILL_COUNT_W-1:0]  wr_ptr;
        logic [FILL_COUNT_W-1:0]  rd_ptr;
        logic                     busy;
        logic [ELAPSED_W-1:0]     elapsed;
        logic [3:0]               bit_pos;
        logic [7:0]               shreg;
        logic                     line_prev;
        logic [BIT_TICKS_W-1:0]   bit_ticks;
        logic [FIRST_TICKS_W-1:0] first_ticks;
        result_t                  expected_status [$];
        int                       failures;

        function new();
            wr_ptr = '0;
            rd_ptr = '0;
            busy = 1'b0;
            elapsed = '0;
            bit_pos = '0;
            shreg = '0;
            line_prev = 1'b1;
            bit_ticks = BIT_TICKS_RESET;
            first_ticks = FIRST_TICKS_RESET;
            failures = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_BIT_TICKS)
                bit_ticks = value[BIT_TICKS_W-1:0];
            else if (idx == REG_FIRST_SAMPLE_TICKS)
                first_ticks = value[FIRST_TICKS_W-1:0];
        endfunction

        // Advance one tick and queue the status seen before it
        function void take_sample(sample_t s);
            result_t                 status;
            logic [FILL_COUNT_W-1:0] fill;
            logic [ELAPSED_W-1:0]    target;
            logic                    push;
            fill = wr_ptr - rd_ptr;
            push = 1'b0;
            status.head_valid = (fill != '0);
            status.head_byte = (fill != '0) ? store[rd_ptr] : 8'h00;
            status.fill_count = fill;
            status.receiving = busy;

            // Sample bits on their tick, or look for a start edge while idle
            if (busy)
            begin
                if (bit_pos == 4'd0)
                    target = ELAPSED_W'(first_ticks);
                else
                    target = ELAPSED_W'(bit_ticks);
                elapsed = elapsed + ELAPSED_W'(1);
                if (elapsed >= target)
                begin
                    elapsed = '0;
                    if (bit_pos < 4'(DATA_BITS))
                    begin
                        shreg = {s.rx_level, shreg[7:1]};
                        bit_pos = bit_pos + 4'd1;
                    end
                    else
                    begin
                        push = 1'b1;
                        busy = 1'b0;
                        bit_pos = '0;
                    end
                end
            end
            else if (line_prev && !s.rx_level)
            begin
                busy = 1'b1;
                elapsed = '0;
                bit_pos = '0;
                shreg = '0;
            end
            line_prev = s.rx_level;

            // Clear wins over pop; the push sees the updated read pointer
            if (s.clear)
            begin
                wr_ptr = '0;
                rd_ptr = '0;
            end
            else if (s.pop_req && fill != '0)
                rd_ptr = rd_ptr + FILL_COUNT_W'(1);
            if (push && (wr_ptr + FILL_COUNT_W'(1)) != rd_ptr)
            begin
                store[wr_ptr] = shreg;
                wr_ptr = wr_ptr + FILL_COUNT_W'(1);
            end
            expected_status.push_back(status);
        endfunction

        function void check_status(result_t got);
            result_t want;
            if (expected_status.size() == 0)
            begin
                $error("status with no tick pending: %p", got);
                failures++;
                return;
            end
            want = expected_status.pop_front();
            if (got.head_byte !== want.head_byte)
            begin
                $error("head_byte: expected %0h, got %0h", want.head_byte, got.head_byte);
                failures++;
            end
            if (got.head_valid !== want.head_valid)
            begin
                $error("head_valid: expected %0d, got %0d", want.head_valid, got.head_valid);
                failures++;
            end
            if (got.fill_count !== want.fill_count)
            begin
                $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
                failures++;
            end
            if (got.receiving !== want.receiving)
            begin
                $error("receiving: expected %0d, got %0d", want.receiving, got.receiving);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic sender_idles;
    logic receiver_stalls;
    int cycles = 0;
    int ticks_sent = 0;

    rx_fifo_tracker tracker;

    urxf_stream_if #(.data_t(sample_t)) sample_ch ();
    urxf_stream_if #(.data_t(result_t)) result_ch ();

    uart_rx_with_ring_fifo_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Track accepted ticks and check statuses at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
                tracker.take_sample(sample_ch.data);
            if (result_ch.valid && result_ch.ready)
                tracker.check_status(result_ch.data);
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Stall the status channel at random
    initial
    begin
        int hold;
        hold = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                result_ch.ready = 1'b0;
            end
            else
            begin
                result_ch.ready = 1'b1;
                if (receiver_stalls && $urandom_range(0, 99) < 25)
                    hold = pick_gap();
            end
        end
    end

    // Present one request and hold it until accepted; entered and left at a falling edge
    task automatic send_tick(input logic level, input logic pop, input logic clr);
        sample_t s;
        int gap;
        s.rx_level = level;
        s.pop_req = pop;
        s.clear = clr;
        gap = (sender_idles && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0)
        begin
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid = 1'b1;
        sample_ch.data = s;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic send_line(input logic level, input int pop_pct, input int clear_pct);
        send_tick(level, $urandom_range(0, 99) < pop_pct, $urandom_range(0, 99) < clear_pct);
    endtask

    // Send one well-formed frame with a random byte at the current bit period
    task automatic send_frame(input int pop_pct, input int clear_pct);
        logic [7:0] value;
        int period;
        int n;
        value = 8'($urandom_range(0, 255));
        period = (tracker.bit_ticks == '0) ? 1 : int'(tracker.bit_ticks);
        n = $urandom_range(1, 3);
        repeat (n) send_line(1'b1, pop_pct, clear_pct);
        while (tracker.busy)
            send_line(1'b1, pop_pct, clear_pct);
        repeat (period) send_line(1'b0, pop_pct, clear_pct);
        for (int i = 0; i < DATA_BITS; i++)
            repeat (period) send_line(value[i], pop_pct, clear_pct);
        do
            send_line(1'b1, pop_pct, clear_pct);
        while (tracker.busy);
    endtask

    // Send a frame with no idle line around it; needs one-tick bit and first-sample timing
    task automatic send_tight_frame();
        logic [7:0] value;
        value = 8'($urandom_range(0, 255));
        send_tick(1'b0, 1'b0, 1'b0);
        for (int i = 0; i < DATA_BITS; i++)
            send_tick(value[i], 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
    endtask

    // Mix frames with line noise for about n_ticks requests
    task automatic run_traffic(input int n_ticks, input int pop_pct, input int clear_pct);
        int start;
        int n;
        start = ticks_sent;
        while (ticks_sent - start < n_ticks)
        begin
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 12)
            begin
                n = $urandom_range(1, 8);
                repeat (n) send_line(1'($urandom_range(0, 1)), pop_pct, clear_pct);
            end
            else
            begin
                send_frame(pop_pct, clear_pct);
            end
        end
    endtask

    // Hold off the sender until every status has come back
    task automatic wait_drained();
        sample_ch.valid = 1'b0;
        while (tracker.expected_status.size() != 0)
            @(negedge clk);
    endtask

    // Let any frame finish and empty the status queue before a register write
    task automatic settle();
        while (tracker.busy)
            send_tick(1'b1, 1'b0, 1'b0);
        wait_drained();
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        tracker.set_reg(idx, value);
    endtask

    initial
    begin
        logic [7:0] pattern;
        int bits;
        int first;
        tracker = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
        sample_ch.valid = 1'b0;
        sample_ch.data = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Zero timing registers act as one tick; an unknown index is ignored
        write_reg(REG_BIT_TICKS, '0);
        write_reg(REG_FIRST_SAMPLE_TICKS, '0);
        write_reg(REG_UNUSED, 17'h1ffff);

        // Pop when empty, then clear together with pop
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);
        // All-ones byte; falling line on the closing tick is ignored, clear keeps the byte
        send_tick(1'b0, 1'b0, 1'b0);
        repeat (DATA_BITS) send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
        // Byte with falling edges inside the frame; pop lands on the push tick
        pattern = 8'h52;
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        for (int i = 0; i < DATA_BITS; i++)
            send_tick(pattern[i], 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        settle();

        // Fastest timing: fill the FIFO past full, then mixed traffic
        write_reg(REG_BIT_TICKS, 17'd1);
        write_reg(REG_FIRST_SAMPLE_TICKS, 17'd1);
        repeat (FIFO_DEPTH_DEFAULT) send_tight_frame();
        run_traffic(30, 60, 2);
        wait_drained();
        run_traffic(20, 40, 2);
        settle();

        // Assorted moderate timings
        repeat (2)
        begin
            bits = $urandom_range(2, 6);
            first = $urandom_range(1, 3 * bits);
            write_reg(REG_BIT_TICKS, 17'(bits));
            write_reg(REG_FIRST_SAMPLE_TICKS, 17'(first));
            run_traffic(15, 35, 2);
            settle();
        end

        // Slower timing: one full frame with no idling
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
        write_reg(REG_BIT_TICKS, 17'd8);
        write_reg(REG_FIRST_SAMPLE_TICKS, 17'd12);
        send_frame(40, 1);
        settle();
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;

        write_reg(REG_BIT_TICKS, 17'd3);
        write_reg(REG_FIRST_SAMPLE_TICKS, 17'd4);
        run_traffic(20, 30, 2);

        settle();
        repeat (5) @(negedge clk);
        if (tracker.failures == 0 && tracker.expected_status.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
